// File: src/dinit_pkg.sv
// dinit_pkg: shared types and codes for the display init sequence parser
// no dependencies; imported by dinit_step and display_init_sequence_parser
package dinit_pkg;

	typedef enum logic [1:0] {
		PH_MARKER,
		PH_CMD,
		PH_DATA,
		PH_DELAY
	} phase_t;

	typedef enum logic [2:0] {
		KIND_CMD   = 3'd0,
		KIND_DATA  = 3'd1,
		KIND_DELAY = 3'd2,
		KIND_DONE  = 3'd3,
		KIND_ERROR = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_MARKER   = 3'd1,
		ERR_VALUE    = 3'd2,
		ERR_TOO_MANY = 3'd3,
		ERR_UNKNOWN  = 3'd4,
		ERR_NO_END   = 3'd5
	} err_t;

	localparam int TOKEN_W = 16;
	localparam int VALUE_W = 15;

	localparam logic [TOKEN_W-1:0] MK_WRITE = 16'hFFFF;
	localparam logic [TOKEN_W-1:0] MK_DELAY = 16'hFFFE;
	localparam logic [TOKEN_W-1:0] MK_END   = 16'hFFFD;

	typedef struct packed {
		logic               emit;
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		err_t               err;
	} result_t;

endpackage

// File: src/dinit_step.sv
// dinit_step: combinational phase update for one token
// depends on dinit_pkg
module dinit_step import dinit_pkg::*; #(
	parameter int MAX_SEQUENCE     = 512,
	parameter int MAX_WRITE_VALUES = 64,
	parameter int PW               = $clog2(MAX_SEQUENCE),
	parameter int CW               = $clog2(MAX_WRITE_VALUES + 1)
) (
	input  logic signed [TOKEN_W-1:0] token,
	input  phase_t                    phase,
	input  logic [CW-1:0]             count,
	input  logic [PW-1:0]             pos,
	output phase_t                    phase_nx,
	output logic [CW-1:0]             count_nx,
	output logic [PW-1:0]             pos_nx,
	output result_t                   res
);

	localparam logic [PW-1:0] LAST_POS  = PW'(MAX_SEQUENCE - 1);
	localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_WRITE_VALUES);

	logic               neg;
	logic [VALUE_W-1:0] byte_val;

	assign neg      = token[TOKEN_W-1];
	assign byte_val = {{(VALUE_W-8){1'b0}}, token[7:0]};

	always_comb begin
		phase_nx  = phase;
		count_nx  = count;
		pos_nx    = pos + PW'(1);
		res.emit  = 1'b0;
		res.kind  = KIND_DONE;
		res.value = '0;
		res.err   = ERR_NONE;

		if (pos >= LAST_POS && token != MK_END) begin
			res.emit = 1'b1;
			res.kind = KIND_ERROR;
			res.err  = ERR_NO_END;
		end else if (phase == PH_CMD || phase == PH_DELAY) begin
			res.emit = 1'b1;
			if (neg) begin
				res.kind = KIND_ERROR;
				res.err  = ERR_VALUE;
			end else if (phase == PH_CMD) begin
				phase_nx  = PH_DATA;
				count_nx  = CW'(1);
				res.kind  = KIND_CMD;
				res.value = byte_val;
			end else begin
				phase_nx  = PH_MARKER;
				res.kind  = KIND_DELAY;
				res.value = token[VALUE_W-1:0];
			end
		end else if (phase == PH_DATA && !neg) begin
			res.emit = 1'b1;
			if (count >= MAX_COUNT) begin
				res.kind = KIND_ERROR;
				res.err  = ERR_TOO_MANY;
			end else begin
				count_nx  = count + CW'(1);
				res.kind  = KIND_DATA;
				res.value = byte_val;
			end
		end else if (!neg) begin
			res.emit = 1'b1;
			res.kind = KIND_ERROR;
			res.err  = ERR_MARKER;
		end else begin
			// marker due; a negative token inside a write lands here too
			count_nx = '0;
			case (token)
				MK_WRITE: phase_nx = PH_CMD;
				MK_DELAY: phase_nx = PH_DELAY;
				MK_END: begin
					res.emit = 1'b1;
					res.kind = KIND_DONE;
				end
				default: begin
					res.emit = 1'b1;
					res.kind = KIND_ERROR;
					res.err  = ERR_UNKNOWN;
				end
			endcase
		end

		// done and every error start a new sequence
		if (res.emit && (res.kind == KIND_DONE || res.kind == KIND_ERROR)) begin
			phase_nx = PH_MARKER;
			count_nx = '0;
			pos_nx   = '0;
		end
	end

endmodule

// File: src/display_init_sequence_parser.sv
// display_init_sequence_parser: top level, token register, phase state, result register
// depends on dinit_pkg and dinit_step
// a token goes into the token register; its result, if any, into the result register
// one token per cycle while in_stall is low, set by the combinational phase update
// a token that causes no result still passes through the update stage
// reset clears phase, write value count, sequence position and both valid flags
module display_init_sequence_parser import dinit_pkg::*; #(
	parameter int MAX_SEQUENCE     = 512,
	parameter int MAX_WRITE_VALUES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [TOKEN_W-1:0] token,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [2:0]                out_kind,
	output logic [VALUE_W-1:0]        out_value,
	output logic [2:0]                error_code
);

	localparam int PW = $clog2(MAX_SEQUENCE);
	localparam int CW = $clog2(MAX_WRITE_VALUES + 1);

	logic signed [TOKEN_W-1:0] token_s1;
	logic                      valid_s1;
	logic                      valid_s2;
	result_t                   res_s2;

	phase_t        phase_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] pos_q;

	phase_t        phase_nx;
	logic [CW-1:0] count_nx;
	logic [PW-1:0] pos_nx;
	result_t       res;

	logic out_free;
	logic adv;

	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	dinit_step #(
		.MAX_SEQUENCE    (MAX_SEQUENCE),
		.MAX_WRITE_VALUES(MAX_WRITE_VALUES),
		.PW              (PW),
		.CW              (CW)
	) u_step (
		.token   (token_s1),
		.phase   (phase_q),
		.count   (count_q),
		.pos     (pos_q),
		.phase_nx(phase_nx),
		.count_nx(count_nx),
		.pos_nx  (pos_nx),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_MARKER;
			count_q  <= '0;
			pos_q    <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				phase_q <= phase_nx;
				count_q <= count_nx;
				pos_q   <= pos_nx;
			end
			if (out_free) begin
				valid_s2 <= adv && res.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			token_s1 <= token;
		end
		if (adv && res.emit && out_free) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = valid_s2;
	assign out_kind   = res_s2.kind;
	assign out_value  = res_s2.value;
	assign error_code = res_s2.err;

endmodule
